// File: rtl/core/scpa_pkg.sv
// Package for the size class pool allocator.
// Holds sizes, item structs and the size-to-class lookup; no dependencies.
package scpa_pkg;

    localparam int SLOTS_PER_CLASS = 128;
    localparam int CLASS_COUNT     = 13;
    localparam int TABLE_LEN       = 13;
    localparam int SEARCHED        = (CLASS_COUNT < TABLE_LEN) ? CLASS_COUNT : TABLE_LEN;
    localparam int POOL_DEPTH      = CLASS_COUNT * SLOTS_PER_CLASS;

    localparam int CLASS_W = 4;
    localparam int SLOT_W  = 7;
    localparam int SIZE_W  = 16;
    localparam int LIVE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int ADDR_W  = $clog2(POOL_DEPTH);

    localparam logic [LIVE_W-1:0] LIVE_MAX = '1;
    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    typedef logic [SIZE_W-1:0] class_bytes_t [TABLE_LEN];
    localparam class_bytes_t CLASS_BYTES = '{
        16'd16, 16'd24, 16'd32, 16'd48, 16'd64, 16'd96, 16'd128,
        16'd192, 16'd256, 16'd384, 16'd512, 16'd768, 16'd1024
    };

    typedef struct packed {
        logic               mode;
        logic [SIZE_W-1:0]  request_size;
        logic [CLASS_W-1:0] free_class;
        logic [SLOT_W-1:0]  free_slot;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [CLASS_W-1:0] granted_class;
        logic [SLOT_W-1:0]  granted_slot;
        logic [LIVE_W-1:0]  class_live_count;
    } out_item_t;

    // First searched class whose size holds the request; oversize takes the last.
    function automatic logic [CLASS_W-1:0] pick_class(input logic [SIZE_W-1:0] size);
        logic [CLASS_W-1:0] cls;
        cls = CLASS_W'(SEARCHED - 1);
        for (int i = SEARCHED - 1; i >= 0; i--) begin
            if (size <= CLASS_BYTES[i]) begin
                cls = CLASS_W'(i);
            end
        end
        return cls;
    endfunction

    function automatic logic [ADDR_W-1:0] pool_addr(input logic [CLASS_W-1:0] cls,
                                                   input logic [SLOT_W-1:0] slot);
        return ADDR_W'(cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(slot);
    endfunction

endpackage

// File: rtl/core/size_class_pool_allocator.sv
// Size class pool allocator top level: LIFO free lists per size class,
// links in one synchronous memory. Depends on scpa_pkg.
//
//   channel | ports              | payload
//   --------+--------------------+-----------------------------
//   request | s_valid, s_ready   | s_item (mode, size, class, slot)
//   result  | m_valid, m_ready   | m_item (status, class, slot, live count)
//
// Allocate passes through ST_POP: the link of the popped slot is read from the
// registered link memory before the head can move. Free skips ST_POP.
// After reset a clearing pass over all CLASS_COUNT*SLOTS_PER_CLASS (1664) entries
// writes the initial links; s_ready stays low meanwhile.
// A result waits in the output register; a new item is taken in ST_IDLE once
// that register is empty or being emptied.
module size_class_pool_allocator
    import scpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_POP   = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [SLOT_W-1:0]  head_reg [CLASS_COUNT];
    logic [LEN_W-1:0]   len_reg  [CLASS_COUNT];
    logic [LIVE_W-1:0]  live_reg [CLASS_COUNT];

    logic [SLOT_W-1:0]  link_mem [POOL_DEPTH];
    logic [SLOT_W-1:0]  link_rd_reg;

    logic [CLASS_W-1:0] clr_cls_reg;
    logic [SLOT_W-1:0]  clr_slot_reg;

    logic [CLASS_W-1:0] pop_cls_reg;
    logic [SLOT_W-1:0]  pop_slot_reg;
    logic               pop_empty_reg;

    logic               m_valid_reg;
    out_item_t          m_item_reg;

    logic               accept;
    logic               is_free;
    logic [CLASS_W-1:0] alloc_cls;
    logic [CLASS_W-1:0] free_cls;
    logic               free_in_range;
    logic               clr_last;
    logic [LIVE_W-1:0]  free_live_next;
    logic [LIVE_W-1:0]  pop_live_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [SLOT_W-1:0]  mem_wdata;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign is_free = (s_item.mode == MODE_FREE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign alloc_cls     = pick_class(s_item.request_size);
    assign free_cls      = (32'(s_item.free_class) < CLASS_COUNT) ? s_item.free_class
                                                                  : CLASS_W'(CLASS_COUNT - 1);
    assign free_in_range = (32'(s_item.free_slot) < SLOTS_PER_CLASS);
    assign clr_last      = (32'(clr_cls_reg) == CLASS_COUNT - 1)
                        && (32'(clr_slot_reg) == SLOTS_PER_CLASS - 1);

    assign free_live_next = (free_in_range && (live_reg[free_cls] != '0))
                          ? live_reg[free_cls] - LIVE_W'(1) : live_reg[free_cls];
    assign pop_live_next  = (!pop_empty_reg && (live_reg[pop_cls_reg] != LIVE_MAX))
                          ? live_reg[pop_cls_reg] + LIVE_W'(1) : live_reg[pop_cls_reg];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && !is_free) begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Clearing pass writes initial links; an in-range free writes the old head as link.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pool_addr(clr_cls_reg, clr_slot_reg);
        mem_wdata = (clr_slot_reg == '0) ? '0 : clr_slot_reg - SLOT_W'(1);
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (accept && is_free && free_in_range) begin
            mem_we    = 1'b1;
            mem_waddr = pool_addr(free_cls, s_item.free_slot);
            mem_wdata = head_reg[free_cls];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (accept && !is_free) begin
            link_rd_reg <= link_mem[pool_addr(alloc_cls, head_reg[alloc_cls])];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cls_reg  <= '0;
            clr_slot_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
                head_reg[c] <= SLOT_W'(SLOTS_PER_CLASS - 1);
                len_reg[c]  <= LEN_W'(SLOTS_PER_CLASS);
                live_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR) begin
                if (32'(clr_slot_reg) == SLOTS_PER_CLASS - 1) begin
                    clr_slot_reg <= '0;
                    clr_cls_reg  <= clr_cls_reg + CLASS_W'(1);
                end else begin
                    clr_slot_reg <= clr_slot_reg + SLOT_W'(1);
                end
            end

            if (accept && is_free) begin
                m_valid_reg                 <= 1'b1;
                m_item_reg.status           <= STATUS_OK;
                m_item_reg.granted_class    <= free_cls;
                m_item_reg.granted_slot     <= s_item.free_slot;
                m_item_reg.class_live_count <= free_live_next;
                if (free_in_range) begin
                    head_reg[free_cls] <= s_item.free_slot;
                    live_reg[free_cls] <= free_live_next;
                    if (len_reg[free_cls] != LEN_MAX) begin
                        len_reg[free_cls] <= len_reg[free_cls] + LEN_W'(1);
                    end
                end
            end else if (state_reg == ST_POP) begin
                m_valid_reg                 <= 1'b1;
                m_item_reg.granted_class    <= pop_cls_reg;
                m_item_reg.class_live_count <= pop_live_next;
                if (pop_empty_reg) begin
                    m_item_reg.status       <= STATUS_EXHAUSTED;
                    m_item_reg.granted_slot <= '0;
                end else begin
                    m_item_reg.status       <= STATUS_OK;
                    m_item_reg.granted_slot <= pop_slot_reg;
                    head_reg[pop_cls_reg]   <= link_rd_reg;
                    len_reg[pop_cls_reg]    <= len_reg[pop_cls_reg] - LEN_W'(1);
                    live_reg[pop_cls_reg]   <= pop_live_next;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !is_free) begin
            pop_cls_reg   <= alloc_cls;
            pop_slot_reg  <= head_reg[alloc_cls];
            pop_empty_reg <= (len_reg[alloc_cls] == '0);
        end
    end

endmodule

// File: rtl/core/scpa_checker.sv
// Port-level checker for the size class pool allocator, bound to the top.
// Depends on scpa_pkg.
module scpa_checker
    import scpa_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // block requests right after reset while the links are cleared
    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during clearing pass");

    // free answers on the next cycle
    a_free_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_item.mode == MODE_FREE) |=> m_valid)
        else $error("free result late");

    // allocate holds s_ready low while in ST_POP, then answers
    a_alloc_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_item.mode == MODE_ALLOC) |=> !s_ready ##1 m_valid)
        else $error("allocate timing broken");

    // exhausted results carry slot zero and a valid class
    a_exhausted_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == STATUS_EXHAUSTED)
            |-> (m_item.granted_slot == '0) && (32'(m_item.granted_class) < CLASS_COUNT))
        else $error("bad exhausted result");

endmodule

bind size_class_pool_allocator scpa_checker u_scpa_checker (.*);

// File: verif/size_class_pool_allocator_tb.sv
// Testbench for size_class_pool_allocator: random and directed allocate/free items,
// checked against a free-list predictor kept in the bench. Depends on scpa_pkg.
module size_class_pool_allocator_tb
    import scpa_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1200;
    localparam int CYCLE_LIMIT = 800000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [SLOT_W-1:0]  slot;
    } held_slot_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    size_class_pool_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Predicted allocator state
    logic [SLOT_W-1:0] list_top    [CLASS_COUNT];
    logic [SLOT_W-1:0] slot_link   [POOL_DEPTH];
    logic [LEN_W-1:0]  list_len    [CLASS_COUNT];
    logic [LIVE_W-1:0] live_allocs [CLASS_COUNT];

    in_item_t   pending_items[$];
    out_item_t  grants_due[$];
    held_slot_t held_slots[$];

    int  queued_count = 0;
    int  taken_count = 0;
    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  alloc_count = 0;
    int  exhausted_count = 0;
    int  free_count = 0;
    int  saturated_count = 0;
    bit  req_taken = 1'b0;
    int  send_gap = 0;
    int  send_quiet = 0;
    int  recv_stall = 0;
    int  recv_quiet = 0;

    function automatic int class_limit(input int k);
        case (k)
            0:       return 16;
            1:       return 24;
            2:       return 32;
            3:       return 48;
            4:       return 64;
            5:       return 96;
            6:       return 128;
            7:       return 192;
            8:       return 256;
            9:       return 384;
            10:      return 512;
            11:      return 768;
            default: return 1024;
        endcase
    endfunction

    function automatic int class_for_size(input logic [SIZE_W-1:0] size);
        for (int i = 0; i < SEARCHED; i++) begin
            if (int'(size) <= class_limit(i)) begin
                return i;
            end
        end
        return SEARCHED - 1;
    endfunction

    function automatic int size_in_class(input int k);
        int lo;
        int hi;
        int roll;
        lo = (k == 0) ? 0 : class_limit(k - 1) + 1;
        hi = class_limit(k);
        if (k == SEARCHED - 1 && $urandom_range(0, 3) == 0) begin
            hi = 65535;
        end
        roll = $urandom_range(0, 9);
        if (roll < 2) begin
            return lo;
        end else if (roll < 4) begin
            return hi;
        end
        return $urandom_range(lo, hi);
    endfunction

    function automatic int random_size();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 65535);
        end
        return size_in_class($urandom_range(0, SEARCHED - 1));
    endfunction

    function automatic int pick_gap(inout int quiet);
        int roll;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        roll = $urandom_range(0, 999);
        if (roll < 5) begin
            quiet = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 600) return 0;
        if (roll < 900) return $urandom_range(1, 3);
        if (roll < 990) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic reset_pool();
        for (int c = 0; c < CLASS_COUNT; c++) begin
            list_top[c]    = SLOT_W'(SLOTS_PER_CLASS - 1);
            list_len[c]    = LEN_W'(SLOTS_PER_CLASS);
            live_allocs[c] = '0;
            for (int s = 0; s < SLOTS_PER_CLASS; s++) begin
                slot_link[c * SLOTS_PER_CLASS + s] = SLOT_W'((s > 0) ? s - 1 : 0);
            end
        end
    endtask

    task automatic apply_request(input in_item_t req);
        int         cls;
        int         slot;
        out_item_t  res;
        held_slot_t h;
        res = '0;
        if (req.mode == MODE_ALLOC) begin
            cls = class_for_size(req.request_size);
            alloc_count++;
            if (list_len[cls] == '0) begin
                res.status = STATUS_EXHAUSTED;
                exhausted_count++;
            end else begin
                slot = int'(list_top[cls]);
                list_top[cls] = slot_link[cls * SLOTS_PER_CLASS + slot];
                list_len[cls] = list_len[cls] - 1'b1;
                if (live_allocs[cls] < LIVE_MAX) begin
                    live_allocs[cls] = live_allocs[cls] + 1'b1;
                end else begin
                    saturated_count++;
                end
                res.status       = STATUS_OK;
                res.granted_slot = SLOT_W'(slot);
                h.cls  = CLASS_W'(cls);
                h.slot = SLOT_W'(slot);
                held_slots.push_back(h);
            end
        end else begin
            free_count++;
            cls  = (int'(req.free_class) < CLASS_COUNT) ? int'(req.free_class) : CLASS_COUNT - 1;
            slot = int'(req.free_slot);
            res.status       = STATUS_OK;
            res.granted_slot = req.free_slot;
            if (slot < SLOTS_PER_CLASS) begin
                slot_link[cls * SLOTS_PER_CLASS + slot] = list_top[cls];
                list_top[cls] = SLOT_W'(slot);
                if (list_len[cls] < LEN_MAX) begin
                    list_len[cls] = list_len[cls] + 1'b1;
                end
                if (live_allocs[cls] > '0) begin
                    live_allocs[cls] = live_allocs[cls] - 1'b1;
                end
            end
        end
        res.granted_class    = CLASS_W'(cls);
        res.class_live_count = live_allocs[cls];
        grants_due.push_back(res);
    endtask

    task automatic queue_alloc(input int size);
        in_item_t it;
        it              = '0;
        it.mode         = MODE_ALLOC;
        it.request_size = SIZE_W'(size);
        it.free_class   = CLASS_W'($urandom);
        it.free_slot    = SLOT_W'($urandom);
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic queue_free(input int cls, input int slot);
        in_item_t it;
        it              = '0;
        it.mode         = MODE_FREE;
        it.request_size = SIZE_W'($urandom);
        it.free_class   = CLASS_W'(cls);
        it.free_slot    = SLOT_W'(slot);
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic queue_held_free();
        int         idx;
        held_slot_t h;
        idx = $urandom_range(0, held_slots.size() - 1);
        h = held_slots[idx];
        held_slots.delete(idx);
        queue_free(int'(h.cls), int'(h.slot));
    endtask

    task automatic wait_items_taken();
        while (taken_count != queued_count) @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (taken_count != queued_count || grants_due.size() > 0) @(negedge aclk);
    endtask

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, grants_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            s_valid <= 1'b1;
        end else begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_item  <= pending_items.pop_front();
                s_valid <= 1'b1;
                send_gap = pick_gap(send_quiet);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            recv_stall = pick_gap(recv_quiet);
        end
    end

    // Monitor: predict on request accept, check on result accept
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (grants_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected result: status=%0d class=%0d slot=%0d live=%0d",
                                 m_item.status, m_item.granted_class, m_item.granted_slot,
                                 m_item.class_live_count);
                    end
                end else begin
                    want = grants_due.pop_front();
                    if (m_item.status !== want.status ||
                        m_item.granted_class !== want.granted_class ||
                        m_item.granted_slot !== want.granted_slot ||
                        m_item.class_live_count !== want.class_live_count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch: expected status=%0d class=%0d slot=%0d live=%0d, got status=%0d class=%0d slot=%0d live=%0d",
                                     want.status, want.granted_class, want.granted_slot,
                                     want.class_live_count, m_item.status,
                                     m_item.granted_class, m_item.granted_slot,
                                     m_item.class_live_count);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                req_taken = 1'b1;
                taken_count++;
                apply_request(s_item);
            end
        end
    end

    int  drain_cls;
    int  sat_cls;
    int  sat_slot;
    int  burst_len;
    int  roll;
    bit  drain_done = 1'b0;
    bit  sat_done = 1'b0;

    initial begin
        reset_pool();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: class boundaries, zero and oversize sizes, clamped classes, double free
        queue_alloc(0);
        queue_alloc(16);
        queue_alloc(17);
        queue_alloc(24);
        queue_alloc(25);
        queue_alloc(48);
        queue_alloc(49);
        queue_alloc(767);
        queue_alloc(768);
        queue_alloc(769);
        queue_alloc(1024);
        queue_alloc(1025);
        queue_alloc(65535);
        queue_alloc(16'h8000);
        queue_alloc(16'h7FFF);
        queue_free(0, 127);
        queue_free(0, 127);
        queue_alloc(1);
        queue_free(4, 0);
        queue_free(15, 0);
        queue_free(13, 7'h55);
        queue_free(12, 7'h7F);
        queue_free(10, 7'h2A);
        queue_alloc(16'hAAAA);
        queue_alloc(16'h5555);

        // Hold off until every result is back
        wait_drained();

        while (queued_count < ITEM_TARGET) begin
            if (!drain_done && queued_count >= 300) begin
                drain_done = 1'b1;
                drain_cls = $urandom_range(0, SEARCHED - 1);
                burst_len = int'(list_len[drain_cls]) + 3;
                for (int i = 0; i < burst_len; i++) begin
                    queue_alloc(size_in_class(drain_cls));
                end
            end else if (!sat_done && queued_count >= 600) begin
                sat_done = 1'b1;
                sat_cls  = (drain_cls + 1 + $urandom_range(0, SEARCHED - 2)) % SEARCHED;
                sat_slot = $urandom_range(0, SLOTS_PER_CLASS - 1);
                burst_len = (int'(list_len[sat_cls]) < 260) ? 260 - int'(list_len[sat_cls]) : 4;
                for (int i = 0; i < burst_len; i++) begin
                    queue_free(sat_cls, sat_slot);
                end
                wait_items_taken();
                burst_len = int'(list_len[sat_cls]) + 2;
                for (int i = 0; i < burst_len; i++) begin
                    queue_alloc(size_in_class(sat_cls));
                end
            end else begin
                burst_len = $urandom_range(4, 24);
                for (int i = 0; i < burst_len; i++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 60) begin
                        queue_alloc(random_size());
                    end else if (roll < 88 && held_slots.size() > 0) begin
                        queue_held_free();
                    end else begin
                        queue_free($urandom_range(0, 15), $urandom_range(0, 127));
                    end
                end
            end
            wait_items_taken();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Ran %0d items: %0d allocates (%0d exhausted, %0d at live limit), %0d frees",
                 taken_count, alloc_count, exhausted_count, saturated_count, free_count);
        $display("Mismatches: %0d, results left over: %0d", mismatch_count, grants_due.size());
        if (mismatch_count == 0 && grants_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/scpa_pkg.sv
rtl/core/size_class_pool_allocator.sv
rtl/core/scpa_checker.sv
verif/size_class_pool_allocator_tb.sv
